// ----- src/msps_pkg.sv -----
package msps_pkg;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] face;
        logic [6:0] point;
        logic [7:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] mode_value;
        logic [3:0]  rounds_used;
    } t_out_item;

    localparam logic [1:0] OP_STORE  = 2'd0;
    localparam logic [1:0] OP_COMMIT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] REG_LIMIT  = 2'd0;
    localparam logic [1:0] REG_ITER   = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;

    typedef struct packed {
        logic clr_round;
        logic acc;
        logic div_start;
        logic div_step;
        logic finish_round;
    } t_cmd;

    typedef struct packed {
        logic acc_last;
        logic div_done;
        logic stop;
    } t_sts;

    function automatic logic [15:0] weight_lut(input logic [7:0] d);
        logic [15:0] w;
        begin
            case (d)
                8'd0:  w = 16'd65535;
                8'd1:  w = 16'd64884;
                8'd2:  w = 16'd62966;
                8'd3:  w = 16'd59895;
                8'd4:  w = 16'd55846;
                8'd5:  w = 16'd51039;
                8'd6:  w = 16'd45723;
                8'd7:  w = 16'd40149;
                8'd8:  w = 16'd34557;
                8'd9:  w = 16'd29154;
                8'd10: w = 16'd24109;
                8'd11: w = 16'd19543;
                8'd12: w = 16'd15527;
                8'd13: w = 16'd12093;
                8'd14: w = 16'd9231;
                8'd15: w = 16'd6907;
                8'd16: w = 16'd5066;
                8'd17: w = 16'd3642;
                8'd18: w = 16'd2567;
                8'd19: w = 16'd1773;
                8'd20: w = 16'd1200;
                8'd21: w = 16'd797;
                8'd22: w = 16'd518;
                8'd23: w = 16'd330;
                8'd24: w = 16'd207;
                8'd25: w = 16'd127;
                8'd26: w = 16'd76;
                8'd27: w = 16'd45;
                8'd28: w = 16'd26;
                8'd29: w = 16'd15;
                8'd30: w = 16'd8;
                8'd31: w = 16'd4;
                8'd32: w = 16'd2;
                8'd33: w = 16'd1;
                8'd34: w = 16'd1;
                default: w = 16'd0;
            endcase
            return w;
        end
    endfunction

endpackage

// ----- src/msps_ctrl.sv -----
module msps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_empty,
    input  msps_pkg::t_sts i_sts,
    output msps_pkg::t_cmd o_cmd,
    output logic          o_done
);
    import msps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ACC  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_CLR  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_CLR;
            end
            S_CLR: begin
                o_cmd.clr_round = 1'b1;
                n_state = i_empty ? S_DIV : S_ACC;
                o_cmd.div_start = i_empty;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.acc_last) begin
                    n_state = S_DIV;
                    o_cmd.div_start = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish_round = 1'b1;
                if (i_sts.stop) begin
                    o_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CLR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule

// ----- src/msps_dp.sv -----
module msps_dp #(
    parameter int HISTORY = 16,
    parameter int POINTS  = 128,
    parameter int FACES   = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  msps_pkg::t_in_item i_item,
    input  logic [4:0]     i_limit,
    input  logic [3:0]     i_max_iter,
    input  logic [15:0]    i_thresh,
    input  msps_pkg::t_cmd i_cmd,
    output msps_pkg::t_sts o_sts,
    output logic           o_empty,
    output logic [15:0]    o_mode,
    output logic [3:0]     o_rounds
);
    import msps_pkg::*;

    localparam int HW = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int CW = $clog2(HISTORY + 1);
    localparam int PW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int FW = (FACES > 1) ? $clog2(FACES) : 1;
    localparam int DEPTH = HISTORY * POINTS * FACES;
    localparam int AW = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [HW-1:0] r_head [FACES];
    logic [CW-1:0] r_count [FACES];

    logic [CW-1:0] lim;
    logic [3:0]    maxr;
    logic          face_ok, pt_ok;
    logic [FW-1:0] fidx;

    always_comb begin
        if (i_limit == 5'd0) lim = CW'(1);
        else if (32'(i_limit) > HISTORY) lim = CW'(HISTORY);
        else lim = CW'(i_limit);
        maxr = (i_max_iter == 4'd0) ? 4'd1 : i_max_iter;
        face_ok = 32'(i_item.face) < FACES;
        pt_ok = 32'(i_item.point) < POINTS;
        fidx = FW'(i_item.face);
    end

    function automatic logic [AW-1:0] addr(input logic [FW-1:0] f, input logic [HW-1:0] s,
                                           input logic [PW-1:0] p);
        return AW'((32'(f) * HISTORY + 32'(s)) * POINTS + 32'(p));
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_load && i_item.op == OP_STORE && face_ok && pt_ok)
            mem[addr(fidx, r_head[fidx], PW'(i_item.point))] <= i_item.sample_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < FACES; f++) begin
                r_head[f] <= '0;
                r_count[f] <= '0;
            end
        end else if (i_load && i_item.op == OP_COMMIT && face_ok) begin
            r_head[fidx] <= ((CW + 1)'(r_head[fidx]) + 1'b1 >= (CW + 1)'(lim)) ? '0
                            : r_head[fidx] + 1'b1;
            r_count[fidx] <= ((CW + 1)'(r_count[fidx]) + 1'b1 > (CW + 1)'(lim)) ? lim
                             : r_count[fidx] + 1'b1;
        end
    end

    // query state
    logic [FW-1:0] r_qf;
    logic [PW-1:0] r_qp;
    logic [CW-1:0] r_n;
    logic [3:0]    r_maxr;
    logic [15:0]   r_cur;
    logic [3:0]    r_rounds;
    logic [CW-1:0] r_k;
    logic          r_rd_vld;
    logic [7:0]    r_rd;
    logic [35:0]   r_up;
    logic [20:0]   r_down;
    logic [43:0]   r_rem;
    logic [43:0]   r_quo;
    logic [5:0]    r_dcnt;
    logic          r_nowt;
    logic [CW-1:0] cnt_sel;

    assign cnt_sel = (r_count[fidx] > lim) ? lim : r_count[fidx];
    assign o_empty = (r_n == '0);

    // memory read: address issued in acc cycles, data registered in the next cycle
    logic          rd_issue;
    logic [7:0]    x, d;
    logic [15:0]   w;
    assign rd_issue = i_cmd.acc && (r_k < r_n);
    always_ff @(posedge i_clk) begin
        if (rd_issue) r_rd <= mem[addr(r_qf, HW'(r_k), r_qp)];
    end
    assign x = r_cur[15:8];
    assign d = (x > r_rd) ? x - r_rd : r_rd - x;
    assign w = weight_lut(d);

    assign o_sts.acc_last = r_rd_vld && (r_k == r_n);

    // restoring division of (up<<8) by down, 44-bit dividend
    logic [44:0] trial;
    assign trial = {r_rem[43:0], r_quo[43]} - 45'(r_down);
    assign o_sts.div_done = r_nowt || (r_dcnt == 6'd0);

    logic [15:0] next, diff;
    assign next = r_nowt ? {x, 8'd0} : r_quo[15:0];
    assign diff = (next > r_cur) ? next - r_cur : r_cur - next;
    assign o_sts.stop = (diff <= i_thresh) || (r_rounds + 4'd1 >= r_maxr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            if (i_load) begin
                r_qf <= fidx;
                r_qp <= PW'(i_item.point);
                r_n <= (face_ok && pt_ok) ? cnt_sel : '0;
                r_maxr <= maxr;
                r_cur <= {i_item.sample_value, 8'd0};
                r_rounds <= '0;
            end
            if (i_cmd.clr_round) begin
                r_k <= '0;
                r_up <= '0;
                r_down <= '0;
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.acc) begin
                if (rd_issue) r_k <= r_k + 1'b1;
                r_rd_vld <= rd_issue;
                if (r_rd_vld) begin
                    r_up <= r_up + 36'(r_rd * w);
                    r_down <= r_down + 21'(w);
                end
            end
            if (i_cmd.div_start) begin
                r_nowt <= o_empty ||
                          ((i_cmd.acc ? (r_down + 21'(r_rd_vld ? w : 16'd0)) : r_down) == '0);
            end
            if (i_cmd.div_step && !o_sts.div_done) begin
                r_dcnt <= r_dcnt - 1'b1;
                if (!trial[44]) begin
                    r_rem <= trial[43:0];
                    r_quo <= {r_quo[42:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[42:0], r_quo[43]};
                    r_quo <= {r_quo[42:0], 1'b0};
                end
            end
            if (i_cmd.div_start) begin
                r_rem <= '0;
                r_quo <= {i_cmd.acc ? (r_up + 36'(r_rd_vld ? r_rd * w : 24'd0)) : r_up, 8'd0};
                r_dcnt <= 6'd44;
            end
            if (i_cmd.finish_round) begin
                r_cur <= next;
                r_rounds <= r_rounds + 1'b1;
            end
        end
    end

    assign o_mode = next;
    assign o_rounds = r_rounds + 4'd1;
endmodule

// ----- src/mean_shift_patch_mode_seeker_unit.sv -----
// Store and commit: result registered on accept. Query: a start step, then per round
// a clear step, accumulation over the n stored patches (one memory read per cycle),
// bit-serial division and a finishing step; up to 15 rounds.
// One item at a time; the output register frees the input side.
// Synchronous active-low reset clears control, output valid, heads and counts and loads
// the configuration defaults; patch memory and datapath registers are not cleared.
module mean_shift_patch_mode_seeker_unit #(
    parameter int HISTORY = 16,
    parameter int POINTS  = 128,
    parameter int FACES   = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  msps_pkg::t_in_item    i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output msps_pkg::t_out_item   o_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import msps_pkg::*;

    logic [4:0]  r_limit;
    logic [3:0]  r_iter;
    logic [15:0] r_thresh;
    logic        r_busy;
    logic        r_oval;
    t_out_item   r_out;
    t_cmd        cmd;
    t_sts        sts;
    logic        empty, done, accept, start;
    logic [15:0] mode;
    logic [3:0]  rounds;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 5'd10;
            r_iter <= 4'd10;
            r_thresh <= 16'd256;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_LIMIT:  r_limit <= pwdata[4:0];
                REG_ITER:   r_iter <= pwdata[3:0];
                REG_THRESH: r_thresh <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            REG_LIMIT:  prdata = {27'd0, r_limit};
            REG_ITER:   prdata = {28'd0, r_iter};
            REG_THRESH: prdata = {16'd0, r_thresh};
            default:    prdata = '0;
        endcase
    end

    assign o_stall = r_busy || (r_oval && i_stall);
    assign accept = i_valid && !o_stall;
    assign start = accept && i_data.op == OP_QUERY;

    msps_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_empty(empty),
        .i_sts(sts), .o_cmd(cmd), .o_done(done)
    );

    msps_dp #(.HISTORY(HISTORY), .POINTS(POINTS), .FACES(FACES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(accept), .i_item(i_data),
        .i_limit(r_limit), .i_max_iter(r_iter), .i_thresh(r_thresh),
        .i_cmd(cmd), .o_sts(sts), .o_empty(empty), .o_mode(mode), .o_rounds(rounds)
    );

    // empty flag is from the registered count, so it is used in the cycle after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            if (done || (accept && !start)) r_oval <= 1'b1;
            else if (o_valid && !i_stall) r_oval <= 1'b0;
            if (start) r_busy <= 1'b1;
            if (accept && !start) r_out <= '0;
            if (done) begin
                r_busy <= 1'b0;
                r_out.mode_value <= mode;
                r_out.rounds_used <= rounds;
            end
        end
    end
    assign o_valid = r_oval;
    assign o_data = r_out;

`ifndef SYNTH
    a_no_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !done || !r_oval) else $error("result while output full");
    a_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> rounds != 4'd0) else $error("zero rounds");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_stall) else $error("accept during query");
`endif
endmodule

// ----- sim/mode_seeker_checker.sv -----
`timescale 1ns / 1ps
module mode_seeker_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  msps_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  msps_pkg::t_out_item i_out_data,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [3:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output int                  o_fail_count
);
    import msps_pkg::*;

    localparam int HIST = 16;
    localparam int PTS = 128;
    localparam int NFACE = 6;

    localparam logic [15:0] GAUSS [0:34] = '{
        16'd65535, 16'd64884, 16'd62966, 16'd59895, 16'd55846, 16'd51039, 16'd45723,
        16'd40149, 16'd34557, 16'd29154, 16'd24109, 16'd19543, 16'd15527, 16'd12093,
        16'd9231, 16'd6907, 16'd5066, 16'd3642, 16'd2567, 16'd1773, 16'd1200,
        16'd797, 16'd518, 16'd330, 16'd207, 16'd127, 16'd76, 16'd45, 16'd26,
        16'd15, 16'd8, 16'd4, 16'd2, 16'd1, 16'd1
    };

    logic [7:0]  patch_mem [NFACE][HIST][PTS];
    logic [3:0]  head [NFACE];
    logic [4:0]  count [NFACE];
    logic [4:0]  limit_reg;
    logic [3:0]  iter_reg;
    logic [15:0] thresh_reg;
    t_out_item   mode_q [$];

    function automatic int eff_limit();
        int l;
        l = limit_reg;
        if (l < 1) l = 1;
        if (l > HIST) l = HIST;
        return l;
    endfunction

    function automatic t_out_item seek_mode(input int f, input int p, input bit ok,
                                            input logic [7:0] start);
        t_out_item r;
        int n;
        int maxr;
        int rounds;
        logic [31:0] cur, nxt, diff, x, xi, d;
        logic [63:0] up, down;
        n = 0;
        maxr = (iter_reg == 0) ? 1 : iter_reg;
        cur = {16'd0, start, 8'd0};
        rounds = 0;
        if (ok) begin
            n = count[f];
            if (n > eff_limit()) n = eff_limit();
        end
        forever begin
            x = cur >> 8;
            up = 0;
            down = 0;
            for (int k = 0; k < n; k++) begin
                xi = patch_mem[f][k][p];
                d = (x > xi) ? x - xi : xi - x;
                d = d & 32'hFF;
                if (d <= 34) begin
                    up += xi * GAUSS[d];
                    down += GAUSS[d];
                end
            end
            nxt = (down != 0) ? 32'((up << 8) / down) : (x << 8);
            diff = (nxt > cur) ? nxt - cur : cur - nxt;
            cur = nxt;
            rounds++;
            if (diff <= thresh_reg || rounds >= maxr) break;
        end
        r.mode_value = cur[15:0];
        r.rounds_used = 4'(rounds);
        return r;
    endfunction

    function automatic t_out_item apply_item(input t_in_item it);
        t_out_item r;
        bit face_ok, ok;
        int h, c;
        r = '0;
        face_ok = it.face < NFACE;
        ok = face_ok && it.point < PTS;
        case (it.op)
            OP_STORE: begin
                if (ok) patch_mem[it.face][head[it.face]][it.point] = it.sample_value;
            end
            OP_COMMIT: begin
                if (face_ok) begin
                    h = head[it.face] + 1;
                    c = count[it.face] + 1;
                    if (h >= eff_limit()) h = 0;
                    if (c > eff_limit()) c = eff_limit();
                    head[it.face] = 4'(h);
                    count[it.face] = 5'(c);
                end
            end
            OP_QUERY: r = seek_mode(it.face, it.point, ok, it.sample_value);
            default: r = '0;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            for (int f = 0; f < NFACE; f++) begin
                head[f] = '0;
                count[f] = '0;
                for (int s = 0; s < HIST; s++)
                    for (int p = 0; p < PTS; p++) patch_mem[f][s][p] = '0;
            end
            limit_reg = 5'd10;
            iter_reg = 4'd10;
            thresh_reg = 16'd256;
            mode_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_LIMIT:  limit_reg = i_pwdata[4:0];
                    REG_ITER:   iter_reg = i_pwdata[3:0];
                    REG_THRESH: thresh_reg = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) mode_q = {mode_q, apply_item(i_in_data)};
            if (i_out_valid && !i_out_stall) begin
                if (mode_q.size() == 0) begin
                    $display("%0t: unexpected transfer, actual mode=%h rounds=%0d", $time,
                             i_out_data.mode_value, i_out_data.rounds_used);
                    o_fail_count++;
                end else begin
                    want = mode_q.pop_front();
                    if (want.mode_value !== i_out_data.mode_value) begin
                        $display("%0t: mode_value expected %h actual %h", $time,
                                 want.mode_value, i_out_data.mode_value);
                        o_fail_count++;
                    end
                    if (want.rounds_used !== i_out_data.rounds_used) begin
                        $display("%0t: rounds_used expected %0d actual %0d", $time,
                                 want.rounds_used, i_out_data.rounds_used);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import msps_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int NFACE = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in_item    i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out_item   o_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;

    int sent = 0;
    int got = 0;
    bit idle_on = 1'b0;
    bit hold_req = 1'b0;

    // shadow of ring state, only to keep queries off unwritten slots
    bit   written [NFACE][16][4];
    int   sh_head [NFACE];
    int   sh_count [NFACE];
    int   sh_limit = 10;
    logic [6:0] hot_pts [4] = '{7'd0, 7'd1, 7'd2, 7'd127};

    mean_shift_patch_mode_seeker_unit dut (.*);

    mode_seeker_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_data(o_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_fail_count(fail_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) if (o_valid && !i_stall) got++;

    initial begin
        #20ms;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    function automatic int hot_idx(input logic [6:0] p);
        for (int i = 0; i < 4; i++) if (hot_pts[i] == p) return i;
        return -1;
    endfunction

    task automatic send(input logic [1:0] op, input logic [2:0] face, input logic [6:0] point,
                        input logic [7:0] val);
        t_in_item it;
        int hi, h;
        it.op = op;
        it.face = face;
        it.point = point;
        it.sample_value = val;
        if (op == OP_QUERY && face < NFACE) begin
            hi = hot_idx(point);
            h = (sh_count[face] < sh_limit) ? sh_count[face] : sh_limit;
            for (int s = 0; s < h; s++)
                if (hi < 0 || !written[face][s][hi]) it.face = 3'd6 + 3'($urandom_range(0, 1));
        end
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (o_stall);
        sent++;
        if (it.face < NFACE) begin
            if (it.op == OP_STORE) begin
                hi = hot_idx(it.point);
                if (hi >= 0) written[it.face][sh_head[it.face] % 16][hi] = 1'b1;
            end else if (it.op == OP_COMMIT) begin
                sh_head[it.face]++;
                if (sh_head[it.face] >= sh_limit) sh_head[it.face] = 0;
                if (sh_count[it.face] < sh_limit) sh_count[it.face]++;
            end
        end
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int lim, input int iters, input int thr);
        i_valid <= 1'b0;
        wait (got >= sent);
        repeat (10) @(posedge i_clk);
        reg_write(REG_LIMIT, lim);
        reg_write(REG_ITER, iters);
        reg_write(REG_THRESH, thr);
        sh_limit = (lim < 1) ? 1 : (lim > 16) ? 16 : lim;
    endtask

    task automatic fill_patch(input logic [2:0] face, input int center, input bit wide);
        int v;
        for (int i = 0; i < 4; i++) begin
            v = wide ? $urandom_range(0, 255) : center + $urandom_range(0, 40) - 20;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            send(OP_STORE, face, hot_pts[(i + face) % 4], 8'(v));
        end
        if ($urandom_range(0, 1)) send(OP_STORE, face, 7'($urandom), 8'($urandom));
        send(OP_COMMIT, face, 7'($urandom), 8'($urandom));
    endtask

    task automatic random_phase(input int items);
        int start_cnt;
        int r;
        int center [NFACE];
        for (int f = 0; f < NFACE; f++) center[f] = $urandom_range(0, 255);
        start_cnt = sent;
        while (sent - start_cnt < items) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                r = $urandom_range(0, NFACE - 1);
                if ($urandom_range(0, 7) == 0) center[r] = $urandom_range(0, 255);
                fill_patch(3'(r), center[r], $urandom_range(0, 9) == 0);
            end else if (r < 80) begin
                r = $urandom_range(0, NFACE - 1);
                send(OP_QUERY, 3'(r), hot_pts[$urandom_range(0, 3)],
                     ($urandom_range(0, 1)) ? 8'(center[r] + $urandom_range(0, 30) - 15)
                                            : 8'($urandom));
            end else if (r < 90) begin
                send(OP_NONE, 3'($urandom), 7'($urandom), 8'($urandom));
                send(2'($urandom_range(0, 1)), 3'($urandom_range(6, 7)), 7'($urandom),
                     8'($urandom));
            end else begin
                send(OP_COMMIT, 3'($urandom_range(0, 7)), 7'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        for (int f = 0; f < NFACE; f++) begin
            sh_head[f] = 0;
            sh_count[f] = 0;
            for (int s = 0; s < 16; s++)
                for (int p = 0; p < 4; p++) written[f][s][p] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;

        send(OP_QUERY, 3'd0, 7'd0, 8'd0);
        send(OP_QUERY, 3'd7, 7'd127, 8'd255);
        send(OP_NONE, 3'd7, 7'd127, 8'd255);
        send(OP_COMMIT, 3'd6, 7'd0, 8'd0);
        send(OP_STORE, 3'd7, 7'd127, 8'd255);
        for (int i = 0; i < 4; i++) send(OP_STORE, 3'd0, hot_pts[i], 8'd255);
        send(OP_COMMIT, 3'd0, 7'd0, 8'd0);
        send(OP_QUERY, 3'd0, 7'd127, 8'd0);
        send(OP_QUERY, 3'd0, 7'd0, 8'd250);
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 4; i++) send(OP_STORE, 3'd5, hot_pts[i], 8'(k * 20));
            send(OP_COMMIT, 3'd5, 7'd0, 8'd0);
        end
        send(OP_QUERY, 3'd5, 7'd1, 8'd30);
        send(OP_QUERY, 3'd5, 7'd2, 8'd255);

        hold_req = 1'b1;
        random_phase(150);

        set_config(0, 0, 0);
        random_phase(120);
        set_config(31, 15, 0);
        random_phase(150);
        set_config(16, 15, 65535);
        random_phase(120);
        set_config(1, 1, 1);
        random_phase(120);
        set_config(4, 7, 64);
        random_phase(150);
        set_config($urandom_range(1, 16), $urandom_range(1, 15), $urandom_range(0, 600));
        idle_on = 1'b0;
        random_phase(190);

        i_valid <= 1'b0;
        wait (got >= sent);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

// ----- mean_shift_patch_mode_seeker_unit.f -----
src/msps_pkg.sv
src/msps_ctrl.sv
src/msps_dp.sv
src/mean_shift_patch_mode_seeker_unit.sv
sim/mode_seeker_checker.sv
sim/testbench.sv
